### hdl/lbf_pkg.sv
// Shared types and constants for the learning bridge forwarder.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbf_pkg;

  localparam int LBF_TABLE_ENTRIES = 64;
  localparam int LBF_NUM_PORTS     = 8;
  localparam int LBF_QUEUE_DEPTH   = 2;

  localparam int LBF_MAC_W  = 48;
  localparam int LBF_PORT_W = 3;
  localparam int LBF_MASK_W = 8;

  // ports that exist on this bridge, limited to the 8-bit mask
  localparam logic [LBF_MASK_W-1:0] LBF_PORT_BITS =
    (LBF_NUM_PORTS >= LBF_MASK_W) ? {LBF_MASK_W{1'b1}} :
    LBF_MASK_W'((1 << LBF_NUM_PORTS) - 1);

  // source learn outcome
  localparam logic [1:0] LBF_ACT_KNOWN   = 2'd0;
  localparam logic [1:0] LBF_ACT_LEARNED = 2'd1;
  localparam logic [1:0] LBF_ACT_MOVED   = 2'd2;
  localparam logic [1:0] LBF_ACT_FULL    = 2'd3;

  // classified header as it travels from front to back
  typedef struct packed {
    logic [LBF_MAC_W-1:0]  dst_mac;
    logic [LBF_MAC_W-1:0]  src_mac;
    logic [LBF_PORT_W-1:0] in_port;
    logic                  same_mac;
    logic [LBF_MASK_W-1:0] flood_mask;
  } lbf_item_t;

  // one table entry
  typedef struct packed {
    logic [LBF_PORT_W-1:0] port;
    logic [LBF_MAC_W-1:0]  mac;
  } lbf_entry_t;

endpackage

`default_nettype wire

### hdl/lbf_front.sv
// Input stage: takes headers from the stream, precomputes the flood mask
// and the source/destination equality. Depends on lbf_pkg.
`default_nettype none

module lbf_front
  import lbf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [LBF_MAC_W-1:0]  dst_mac,
  input  wire logic [LBF_MAC_W-1:0]  src_mac,
  input  wire logic [LBF_PORT_W-1:0] in_port,
  input  wire logic [LBF_MASK_W-1:0] domain_mask,
  output      logic                  push_valid,
  input  wire logic                  push_ready,
  output      lbf_item_t             push_item
);

  logic      stg_valid;
  lbf_item_t stg_item;

  assign in_ready   = !stg_valid || push_ready;
  assign push_valid = stg_valid;
  assign push_item  = stg_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_item.dst_mac    <= dst_mac;
      stg_item.src_mac    <= src_mac;
      stg_item.in_port    <= in_port;
      stg_item.same_mac   <= (dst_mac == src_mac);
      stg_item.flood_mask <= domain_mask & ~(LBF_MASK_W'(1) << in_port) & LBF_PORT_BITS;
    end
  end

endmodule

`default_nettype wire

### hdl/lbf_queue.sv
// Short queue of classified headers between front and back.
// Depends on lbf_pkg.
`default_nettype none

module lbf_queue
  import lbf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output      logic      wr_ready,
  input  wire lbf_item_t wr_item,
  output      logic      rd_valid,
  input  wire logic      rd_ready,
  output      lbf_item_t rd_item
);

  localparam int PTR_W = $clog2(LBF_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(LBF_QUEUE_DEPTH + 1);

  lbf_item_t        slots [LBF_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(LBF_QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_ready && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(LBF_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(LBF_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

### hdl/lbf_back.sv
// Table engine: scans the MAC table once per header for source and
// destination, learns or moves the source, builds the result.
// Depends on lbf_pkg.
`default_nettype none

module lbf_back
  import lbf_pkg::*;
#(
  parameter int TABLE_ENTRIES = LBF_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  output      logic                  q_ready,
  input  wire lbf_item_t             q_item,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [LBF_MASK_W-1:0] out_mask,
  output      logic                  dst_known,
  output      logic [1:0]            src_action,
  output      logic [LBF_PORT_W-1:0] old_port,
  output      logic [CNT_W-1:0]      fill
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;

  lbf_entry_t mem [TABLE_ENTRIES];
  lbf_entry_t rdata;
  logic       rvalid;
  logic [IDX_W-1:0] cidx;
  logic [CNT_W-1:0] issue;
  logic             rd_en;

  lbf_item_t             item;
  logic                  src_hit;
  logic [IDX_W-1:0]      src_idx;
  logic [LBF_PORT_W-1:0] src_port;
  logic                  dst_hit;
  logic [LBF_PORT_W-1:0] dst_port;

  logic                  load;
  logic [1:0]            act;
  logic                  known;
  logic [LBF_PORT_W-1:0] fwd_port;
  logic [LBF_MASK_W-1:0] mask;
  logic                  mem_we;
  logic [IDX_W-1:0]      waddr;

  assign q_ready = (state == ST_IDLE);
  assign rd_en   = (state == ST_SCAN) && (issue < fill);
  assign load    = (state == ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    if (src_hit) begin
      act = (src_port == item.in_port) ? LBF_ACT_KNOWN : LBF_ACT_MOVED;
    end else begin
      act = (fill < CNT_W'(TABLE_ENTRIES)) ? LBF_ACT_LEARNED : LBF_ACT_FULL;
    end
    // destination equal to source sees the entry as just updated
    if (item.same_mac && act != LBF_ACT_FULL) begin
      known    = 1'b1;
      fwd_port = item.in_port;
    end else begin
      known    = dst_hit;
      fwd_port = dst_port;
    end
    mask   = known ? ((LBF_MASK_W'(1) << fwd_port) & LBF_PORT_BITS) : item.flood_mask;
    mem_we = load && (act == LBF_ACT_LEARNED || act == LBF_ACT_MOVED);
    waddr  = (act == LBF_ACT_MOVED) ? src_idx : fill[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= '{port: item.in_port, mac: item.src_mac};
    end
    if (rd_en) begin
      rdata <= mem[issue[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvalid <= rd_en;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!rd_en && !rvalid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_IDLE;
            if (act == LBF_ACT_LEARNED) begin
              fill <= fill + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      item    <= q_item;
      issue   <= '0;
      src_hit <= 1'b0;
      dst_hit <= 1'b0;
    end else begin
      if (rd_en) begin
        issue <= issue + 1'b1;
      end
      // entries are unique, so at most one hit per address
      if (rvalid && rdata.mac == item.src_mac) begin
        src_hit  <= 1'b1;
        src_idx  <= cidx;
        src_port <= rdata.port;
      end
      if (rvalid && rdata.mac == item.dst_mac) begin
        dst_hit  <= 1'b1;
        dst_port <= rdata.port;
      end
    end
    cidx <= issue[IDX_W-1:0];
    if (load) begin
      out_mask   <= mask;
      dst_known  <= known;
      src_action <= act;
      old_port   <= (act == LBF_ACT_MOVED) ? src_port : '0;
    end
  end

endmodule

`default_nettype wire

### hdl/mac_learning_bridge_forwarder_unit.sv
// Top level of the learning bridge forwarder: domain register, front
// stage, header queue and table engine. Depends on lbf_pkg and submodules.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  dst_mac, src_mac, in_port
//   m_axis    out  m_axis_tvalid / m_axis_tready  out_mask, dst_known,
//                                                 src_action, old_port
//   cfg       in   domain_mask_we                 domain_mask_wdata
//
// The MAC table memory in the table engine has one read port and is scanned
// once per header. Front stage and a 2-deep queue keep accepting while the engine
// works, until both are full.
// Reset empties the table at once (fill count to zero), domain_mask = all ones.
// A waiting result holds in the output register while the next header is scanned.
`default_nettype none

module mac_learning_bridge_forwarder_unit
  import lbf_pkg::*;
#(
  parameter int TABLE_ENTRIES = LBF_TABLE_ENTRIES
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // dst_mac[47:0], src_mac[95:48], in_port[98:96], zero[103:99]
  input  wire logic [103:0] s_axis_tdata,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_mask[7:0], dst_known[8], src_action[10:9], old_port[13:11], zero[15:14]
  output      logic [15:0]  m_axis_tdata,
  input  wire logic         domain_mask_we,
  input  wire logic [7:0]   domain_mask_wdata
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [LBF_MASK_W-1:0] domain_mask;
  logic                  push_valid;
  logic                  push_ready;
  lbf_item_t             push_item;
  logic                  q_valid;
  logic                  q_ready;
  lbf_item_t             q_item;
  logic [LBF_MASK_W-1:0] out_mask;
  logic                  dst_known;
  logic [1:0]            src_action;
  logic [LBF_PORT_W-1:0] old_port;
  logic [CNT_W-1:0]      fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_mask <= '1;
    end else if (domain_mask_we) begin
      domain_mask <= domain_mask_wdata;
    end
  end

  lbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .dst_mac    (s_axis_tdata[47:0]),
    .src_mac    (s_axis_tdata[95:48]),
    .in_port    (s_axis_tdata[98:96]),
    .domain_mask(domain_mask),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lbf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_item (push_item),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_item (q_item)
  );

  lbf_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_mask  (out_mask),
    .dst_known (dst_known),
    .src_action(src_action),
    .old_port  (old_port),
    .fill      (fill)
  );

  assign m_axis_tdata = {2'b00, old_port, src_action, dst_known, out_mask};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TABLE_ENTRIES))
    else $error("table fill count beyond table size");

  a_old_port_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && src_action != LBF_ACT_MOVED) |-> (old_port == '0))
    else $error("old_port set without a move");

  a_known_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && dst_known) |-> $onehot0(out_mask))
    else $error("known destination forwarded to several ports");

  a_learn_fills: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && src_action == LBF_ACT_LEARNED) |-> (fill != '0))
    else $error("learned source but table empty");
`endif

endmodule

`default_nettype wire
